// ----- sv/fpa_pkg.sv -----
// Shared types and constants for the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 8;
  localparam int OP_WIDTH   = 5;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD      = 5'd0,
    OP_SUB      = 5'd1,
    OP_MUL      = 5'd2,
    OP_DIV      = 5'd3,
    OP_GT       = 5'd4,
    OP_LT       = 5'd5,
    OP_GE       = 5'd6,
    OP_LE       = 5'd7,
    OP_EQ       = 5'd8,
    OP_NE       = 5'd9,
    OP_MIN      = 5'd10,
    OP_MAX      = 5'd11,
    OP_INC      = 5'd12,
    OP_DEC      = 5'd13,
    OP_INTPART  = 5'd14,
    OP_FRACBITS = 5'd15,
    OP_FROMINT  = 5'd16
  } op_e;

  typedef struct packed {
    logic [OP_WIDTH-1:0]          opcode;
    logic signed [WORD_WIDTH-1:0] operand_a;
    logic signed [WORD_WIDTH-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] result_value;
    logic                         compare_true;
    logic                         divide_by_zero;
  } out_t;

  // Division step state: partial remainder, dividend shifting into quotient, divisor.
  typedef struct packed {
    logic [WORD_WIDTH-1:0] rem;
    logic [WORD_WIDTH-1:0] dq;
    logic [WORD_WIDTH-1:0] dvs;
  } dstate_t;

  // Word context riding alongside the divider row.
  typedef struct packed {
    logic                  is_div;
    logic                  dz;
    logic                  cmp;
    logic [WORD_WIDTH-1:0] res;
    logic                  negq;
    logic                  negr;
    logic                  bneg;
    logic [FRAC_BITS-1:0]  fa;
    logic [WORD_WIDTH-1:0] q0;
  } side_t;

endpackage

// ----- sv/fpa_div_cell.sv -----
// One restoring-division step cell with pass-along word context.
`timescale 1ns / 1ps
module fpa_div_cell
  import fpa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  dstate_t st_i,
  input  side_t   sd_i,
  output logic    valid_o,
  output dstate_t st_o,
  output side_t   sd_o
);

  logic            valid_q;
  dstate_t         st_d, st_q;
  side_t           sd_q;
  logic [WORD_WIDTH:0] trial;
  logic [WORD_WIDTH:0] diff;

  always_comb begin
    trial = {st_i.rem, st_i.dq[WORD_WIDTH-1]};
    diff  = trial - {1'b0, st_i.dvs};
    st_d.dvs = st_i.dvs;
    if (!diff[WORD_WIDTH]) begin
      st_d.rem = diff[WORD_WIDTH-1:0];
      st_d.dq  = {st_i.dq[WORD_WIDTH-2:0], 1'b1};
    end else begin
      st_d.rem = trial[WORD_WIDTH-1:0];
      st_d.dq  = {st_i.dq[WORD_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    sd_q <= sd_i;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign sd_o    = sd_q;

endmodule

// ----- sv/fixed_point_alu.sv -----
// Top level of the pipelined fixed-point ALU.
`timescale 1ns / 1ps
// Channel  | Ports                  | Handshake
// ---------+------------------------+---------------------------------
// input    | start, busy, op_i      | word taken when start && !busy
// result   | done_o, res_o          | word valid for one cycle on done_o
//
// Every opcode passes the same path from accept to done_o: one entry
// stage (multiplier, operand setup), 32 cells for the integer-part
// quotient, one sign/fix stage, 32 cells for the fraction quotient and
// the output register.
// A new word is taken every cycle; busy is never raised.
// Reset clears only the valid bits along the pipe; words in flight are lost.
// The receiver cannot stall; results come out in accept order.
module fixed_point_alu
  import fpa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  op_i,
  output logic done_o,
  output out_t res_o
);

  localparam int W       = WORD_WIDTH;
  localparam int F       = FRAC_BITS;
  localparam int LATENCY = 2 * W + 3;

  // ---------------- entry stage ----------------
  logic signed [W-1:0]   a, b;
  logic signed [2*W-1:0] prod;
  logic [W-1:0]          res_c;
  logic                  cmp_c;
  logic                  is_div_c;
  logic [W-1:0]          ip, ip_mag, b_mag;

  assign a    = op_i.operand_a;
  assign b    = op_i.operand_b;
  // (a*b)>>F equals int(a)*b + frac(a)*bh + (frac(a)*bl)>>F exactly
  assign prod = a * b;

  always_comb begin
    res_c    = '0;
    cmp_c    = 1'b0;
    is_div_c = 1'b0;
    unique case (op_i.opcode)
      OP_ADD:      res_c = a + b;
      OP_SUB:      res_c = a - b;
      OP_MUL:      res_c = prod[F +: W];
      OP_DIV:      is_div_c = 1'b1;
      OP_GT:       cmp_c = (a > b);
      OP_LT:       cmp_c = (a < b);
      OP_GE:       cmp_c = (a >= b);
      OP_LE:       cmp_c = (a <= b);
      OP_EQ:       cmp_c = (a == b);
      OP_NE:       cmp_c = (a != b);
      OP_MIN:      res_c = (a < b) ? a : b;
      OP_MAX:      res_c = (a > b) ? a : b;
      OP_INC:      res_c = a + W'(1);
      OP_DEC:      res_c = a - W'(1);
      OP_INTPART:  res_c = a >>> F;
      OP_FRACBITS: res_c = {{(W-F){1'b0}}, a[F-1:0]};
      OP_FROMINT:  res_c = a << F;
      default:     res_c = '0;
    endcase
  end

  // integer part of a, fraction cleared
  assign ip     = {a[W-1:F], {F{1'b0}}};
  assign ip_mag = ip[W-1] ? (~ip + W'(1)) : ip;
  assign b_mag  = b[W-1] ? (~b + W'(1)) : b;

  logic    v0_q;
  dstate_t st0_q;
  side_t   sd0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    st0_q.rem    <= '0;
    st0_q.dq     <= ip_mag;
    st0_q.dvs    <= b_mag;
    sd0_q.is_div <= is_div_c;
    sd0_q.dz     <= is_div_c && (b == '0);
    sd0_q.cmp    <= cmp_c;
    sd0_q.res    <= res_c;
    sd0_q.negq   <= ip[W-1] ^ b[W-1];
    sd0_q.negr   <= ip[W-1];
    sd0_q.bneg   <= b[W-1];
    sd0_q.fa     <= a[F-1:0];
    sd0_q.q0     <= '0;
  end

  // ---------------- first divider row ----------------
  logic    va [0:W];
  dstate_t sta[0:W];
  side_t   sda[0:W];

  assign va[0]  = v0_q;
  assign sta[0] = st0_q;
  assign sda[0] = sd0_q;

  for (genvar i = 0; i < W; i++) begin : g_row_a
    fpa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(va[i]),
      .st_i   (sta[i]),
      .sd_i   (sda[i]),
      .valid_o(va[i+1]),
      .st_o   (sta[i+1]),
      .sd_o   (sda[i+1])
    );
  end

  // ---------------- fix stage: signs, fraction dividend ----------------
  logic [W-1:0] q0_c, r0_c, fp_c, fp_mag;

  assign q0_c   = sda[W].negq ? (~sta[W].dq + W'(1)) : sta[W].dq;
  assign r0_c   = sda[W].negr ? (~sta[W].rem + W'(1)) : sta[W].rem;
  assign fp_c   = (r0_c + {{(W-F){1'b0}}, sda[W].fa}) << F;
  assign fp_mag = fp_c[W-1] ? (~fp_c + W'(1)) : fp_c;

  logic    v1_q;
  dstate_t st1_q;
  side_t   sd1_d;
  side_t   sd1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= va[W];
    end
  end

  // integer quotient rides along; sign now follows the fraction dividend
  always_comb begin
    sd1_d      = sda[W];
    sd1_d.q0   = q0_c;
    sd1_d.negq = fp_c[W-1] ^ sda[W].bneg;
  end

  always_ff @(posedge clk_i) begin
    st1_q.rem <= '0;
    st1_q.dq  <= fp_mag;
    st1_q.dvs <= sta[W].dvs;
    sd1_q     <= sd1_d;
  end

  // ---------------- second divider row ----------------
  logic    vb [0:W];
  dstate_t stb[0:W];
  side_t   sdb[0:W];

  assign vb[0]  = v1_q;
  assign stb[0] = st1_q;
  assign sdb[0] = sd1_q;

  for (genvar i = 0; i < W; i++) begin : g_row_b
    fpa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vb[i]),
      .st_i   (stb[i]),
      .sd_i   (sdb[i]),
      .valid_o(vb[i+1]),
      .st_o   (stb[i+1]),
      .sd_o   (sdb[i+1])
    );
  end

  // ---------------- output stage ----------------
  logic [W-1:0] q1_c, div_res;
  out_t         out_d;
  logic         done_q;
  out_t         out_q;

  assign q1_c    = sdb[W].negq ? (~stb[W].dq + W'(1)) : stb[W].dq;
  assign div_res = (sdb[W].q0 << F) + q1_c;

  always_comb begin
    out_d.compare_true   = sdb[W].cmp;
    out_d.divide_by_zero = sdb[W].dz;
    if (sdb[W].dz) begin
      out_d.result_value = '0;
    end else if (sdb[W].is_div) begin
      out_d.result_value = div_res;
    end else begin
      out_d.result_value = sdb[W].res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vb[W];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign busy   = 1'b0;
  assign done_o = done_q;
  assign res_o  = out_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result strobe missing at fixed latency");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.divide_by_zero) |-> (res_o.result_value == '0))
    else $error("zero divisor gave nonzero result");
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.compare_true) |-> (res_o.result_value == '0 && !res_o.divide_by_zero))
    else $error("comparison word carries a value");
  a_row_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va[W] |=> vb[0])
    else $error("word lost between divider rows");
`endif

endmodule
